>>> rtl/tile_grid_aspect_selector_macros.svh
// Assertion macros for the tile grid aspect selector.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef TILE_GRID_ASPECT_SELECTOR_MACROS_SVH
`define TILE_GRID_ASPECT_SELECTOR_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define TGAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define TGAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tgas_pkg.sv
// Shared types and constants of the tile grid aspect selector.
// No dependencies.
package tgas_pkg;

    localparam int CNT_W      = 4;   // min_tiles / max_tiles
    localparam int TS_W       = 13;  // tile_size
    localparam int TS2_W      = 2 * TS_W;
    localparam int OUT_W      = 4;   // result fields
    localparam int CFG_DATA_W = 13;

    typedef enum logic [1:0] {
        CFG_MIN_TILES,
        CFG_MAX_TILES,
        CFG_TILE_SIZE,
        CFG_USE_THUMB
    } t_cfg_idx;

    localparam logic [CNT_W-1:0] MIN_TILES_RST = 4'd1;
    localparam logic [CNT_W-1:0] MAX_TILES_RST = 4'd12;
    localparam logic [TS_W-1:0]  TILE_SIZE_RST = 13'd448;
    localparam logic             USE_THUMB_RST = 1'b1;

    typedef struct packed {
        logic clear;     // start of a new image: drop the best grid
        logic cand_vld;  // a candidate grid is presented this cycle
    } t_eval_ctl;

endpackage

>>> rtl/tgas_if.sv
// Handshake channels of the tile grid aspect selector: image request,
// grid result and configuration write. Depends on tgas_pkg.
interface tgas_img_if import tgas_pkg::*; #(parameter int DIM_BITS = 16) ();
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] image_height;
    logic [DIM_BITS-1:0] image_width;

    modport source (output valid, output image_height, output image_width, input ready);
    modport sink   (input valid, input image_height, input image_width, output ready);
endinterface

interface tgas_grid_if import tgas_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] tiles_across;
    logic [OUT_W-1:0] tiles_down;
    logic [OUT_W-1:0] image_total;

    modport source (output valid, output tiles_across, output tiles_down,
                    output image_total, input ready);
    modport sink   (input valid, input tiles_across, input tiles_down,
                    input image_total, output ready);
endinterface

interface tgas_cfg_if import tgas_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/tgas_eval.sv
// Candidate evaluator: three-stage pipe that scores one grid per cycle and
// keeps the best one. Depends on tgas_pkg.
module tgas_eval import tgas_pkg::*; #(
    parameter int DIM_BITS = 16,
    parameter int CW       = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_eval_ctl             i_ctl,
    input  logic [DIM_BITS-1:0]   i_w,
    input  logic [DIM_BITS-1:0]   i_h,
    input  logic [2*DIM_BITS:0]   i_area2,
    input  logic [TS2_W-1:0]      i_ts2,
    input  logic [CNT_W-1:0]      i_lo,
    input  logic [CW-1:0]         i_a,
    input  logic [CW-1:0]         i_b,
    input  logic [CW-1:0]         i_p,
    output logic [CW-1:0]         o_best_a,
    output logic [CW-1:0]         o_best_b,
    output logic                  o_best_vld
);

    localparam int EW   = DIM_BITS + CW;
    localparam int XW   = EW + CW;
    localparam int LW   = (CW > CNT_W) ? CW : CNT_W;
    localparam int LIMW = TS2_W + CW;
    localparam int AW   = 2 * DIM_BITS + 1;
    localparam int CMPW = (LIMW > AW) ? LIMW : AW;

    logic [CW-1:0]   w_mx;
    logic [LW-1:0]   w_key;

    logic            r1_vld;
    logic [EW-1:0]   r1_wb;
    logic [EW-1:0]   r1_ah;
    logic [LIMW-1:0] r1_lim;
    logic [CW-1:0]   r1_a, r1_b, r1_p;
    logic [LW-1:0]   r1_key;

    logic            r2_vld;
    logic [EW-1:0]   r2_err;
    logic            r2_t;
    logic [CW-1:0]   r2_a, r2_b, r2_p;
    logic [LW-1:0]   r2_key;

    logic            r_best_vld;
    logic [CW-1:0]   r_best_a, r_best_b, r_best_p;
    logic [EW-1:0]   r_best_err;
    logic            r_best_t;
    logic [LW-1:0]   r_best_key;

    logic [XW-1:0]   w_lhs, w_rhs;
    logic            w_tie_win;
    logic            w_take;

    // first pass of the enumeration that holds this grid
    assign w_mx  = (i_a > i_b) ? i_a : i_b;
    assign w_key = (LW'(w_mx) > LW'(i_lo)) ? LW'(w_mx) : LW'(i_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_ctl.cand_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_wb  <= EW'(i_w) * EW'(i_b);
        r1_ah  <= EW'(i_a) * EW'(i_h);
        r1_lim <= LIMW'(i_ts2) * LIMW'(i_p);
        r1_a   <= i_a;
        r1_b   <= i_b;
        r1_p   <= i_p;
        r1_key <= w_key;

        r2_err <= (r1_wb >= r1_ah) ? (r1_wb - r1_ah) : (r1_ah - r1_wb);
        r2_t   <= CMPW'(i_area2) > CMPW'(r1_lim);
        r2_a   <= r1_a;
        r2_b   <= r1_b;
        r2_p   <= r1_p;
        r2_key <= r1_key;
    end

    // err/(h*b) compared by cross multiplication
    assign w_lhs = XW'(r2_err) * XW'(r_best_b);
    assign w_rhs = XW'(r_best_err) * XW'(r2_b);

    // equal error: ties favored by tile count (later wins) above the rest,
    // the rest by first appearance
    always_comb begin
        w_tie_win = 1'b0;
        if (r2_t != r_best_t) begin
            w_tie_win = r2_t;
        end else if (r2_p != r_best_p) begin
            w_tie_win = r2_t ? (r2_p > r_best_p) : (r2_p < r_best_p);
        end else if (r2_t) begin
            w_tie_win = r2_a > r_best_a;
        end else if (r2_key != r_best_key) begin
            w_tie_win = r2_key < r_best_key;
        end else begin
            w_tie_win = r2_a < r_best_a;
        end
    end

    assign w_take = r2_vld && (!r_best_vld || (w_lhs < w_rhs) ||
                               ((w_lhs == w_rhs) && w_tie_win));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
            r_best_a   <= CW'(1);
            r_best_b   <= CW'(1);
        end else if (i_ctl.clear) begin
            r_best_vld <= 1'b0;
            r_best_a   <= CW'(1);
            r_best_b   <= CW'(1);
        end else if (w_take) begin
            r_best_vld <= 1'b1;
            r_best_a   <= r2_a;
            r_best_b   <= r2_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_err <= r2_err;
            r_best_p   <= r2_p;
            r_best_t   <= r2_t;
            r_best_key <= r2_key;
        end
    end

    assign o_best_a   = r_best_a;
    assign o_best_b   = r_best_b;
    assign o_best_vld = r_best_vld;

endmodule

>>> rtl/tile_grid_aspect_selector.sv
// Top level of the tile grid aspect selector: config registers, grid
// enumerator and result register. Depends on tgas_pkg, tgas_if, tgas_eval.
//
// Usage:
//   i_cfg  : register writes (min_tiles, max_tiles, tile_size, thumbnail enable),
//            always ready; write only while no image request is in flight.
//   i_img  : one request per image (height, width). Ready only when idle.
//   o_grid : one result per request (tiles_across, tiles_down, image_total).
// Sequence:
//   a setup state (w*h and tile_size^2), then one grid a x b per cycle with
//   a*b <= top, top = min(max_tiles, MAX_TILES): sum over a of floor(top/a)
//   grids (35 at top = 12); the drain state then empties the evaluator pipe
//   and the finish state loads the result. A new request is taken only after
//   the last one has loaded its result.
//   Zero height or zero top skips the walk and gives a 1x1 grid.
// Stall: the result register holds while o_grid.ready is low; the next
//   request is taken meanwhile and its result waits until the register frees.
// Reset: synchronous, active low; config returns to 1 / 12 / 448 / 1 and
//   the channels go idle.
`include "tile_grid_aspect_selector_macros.svh"

module tile_grid_aspect_selector import tgas_pkg::*; #(
    parameter int DIM_BITS  = 16,
    parameter int MAX_TILES = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tgas_cfg_if.sink          i_cfg,
    tgas_img_if.sink          i_img,
    tgas_grid_if.source       o_grid
);

    localparam int CW = $clog2(MAX_TILES + 1);
    localparam int TW = (CW > CNT_W) ? CW : CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_min_tiles;
    logic [CNT_W-1:0]      r_max_tiles;
    logic [TS_W-1:0]       r_tile_size;
    logic                  r_use_thumb;

    logic [DIM_BITS-1:0]   r_h, r_w;
    logic [2*DIM_BITS:0]   r_area2;
    logic [TS2_W-1:0]      r_ts2;
    logic [CW-1:0]         r_top;
    logic [CW-1:0]         r_a, r_b, r_p;
    logic                  r_drain;

    logic                  r_out_vld;
    logic [OUT_W-1:0]      r_out_across, r_out_down, r_out_batch;

    logic [TW-1:0]         w_max_ext;
    logic [CW-1:0]         w_top;
    logic [CW:0]           w_p_next, w_a_next;
    t_eval_ctl             w_ctl;
    logic [CW-1:0]         w_best_a, w_best_b;
    logic                  w_best_vld;
    logic [2*CW-1:0]       w_count;
    logic [2*CW:0]         w_batch;
    logic [2*CW-1:0]       w_run_prod;
    logic                  w_load;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_tiles <= MIN_TILES_RST;
            r_max_tiles <= MAX_TILES_RST;
            r_tile_size <= TILE_SIZE_RST;
            r_use_thumb <= USE_THUMB_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MIN_TILES: r_min_tiles <= CNT_W'(i_cfg.data);
                CFG_MAX_TILES: r_max_tiles <= CNT_W'(i_cfg.data);
                CFG_TILE_SIZE: r_tile_size <= TS_W'(i_cfg.data);
                CFG_USE_THUMB: r_use_thumb <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // enumerator
    assign w_max_ext = TW'(r_max_tiles);
    assign w_top     = (w_max_ext > TW'(MAX_TILES)) ? CW'(MAX_TILES) : CW'(w_max_ext);
    assign w_p_next  = (CW+1)'(r_p) + (CW+1)'(r_a);
    assign w_a_next  = (CW+1)'(r_a) + (CW+1)'(1);

    assign w_ctl.clear    = (r_state == ST_SETUP);
    assign w_ctl.cand_vld = (r_state == ST_RUN) && (TW'(r_p) >= TW'(r_min_tiles));

    tgas_eval #(
        .DIM_BITS (DIM_BITS),
        .CW       (CW)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_w        (r_w),
        .i_h        (r_h),
        .i_area2    (r_area2),
        .i_ts2      (r_ts2),
        .i_lo       (r_min_tiles),
        .i_a        (r_a),
        .i_b        (r_b),
        .i_p        (r_p),
        .o_best_a   (w_best_a),
        .o_best_b   (w_best_b),
        .o_best_vld (w_best_vld)
    );

    assign w_count = (2*CW)'(w_best_a) * (2*CW)'(w_best_b);
    assign w_batch = (2*CW+1)'(w_count) +
                     (2*CW+1)'(r_use_thumb && (w_count != (2*CW)'(1)));

    assign i_img.ready = (r_state == ST_IDLE);

    assign w_load = (r_state == ST_FINISH) && (!r_out_vld || o_grid.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_grid.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_img.valid) begin
                        r_h     <= i_img.image_height;
                        r_w     <= i_img.image_width;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_area2 <= {(2*DIM_BITS)'(r_w) * (2*DIM_BITS)'(r_h), 1'b0};
                    r_ts2   <= TS2_W'(r_tile_size) * TS2_W'(r_tile_size);
                    r_top   <= w_top;
                    r_a     <= CW'(1);
                    r_b     <= CW'(1);
                    r_p     <= CW'(1);
                    r_drain <= 1'b0;
                    r_state <= ((r_h != '0) && (w_top != '0)) ? ST_RUN : ST_DRAIN;
                end
                ST_RUN: begin
                    if (w_p_next <= (CW+1)'(r_top)) begin
                        r_b <= r_b + CW'(1);
                        r_p <= CW'(w_p_next);
                    end else if (w_a_next <= (CW+1)'(r_top)) begin
                        r_a <= CW'(w_a_next);
                        r_b <= CW'(1);
                        r_p <= CW'(w_a_next);
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_load) begin
                        r_out_across <= OUT_W'(w_best_a);
                        r_out_down   <= OUT_W'(w_best_b);
                        r_out_batch  <= OUT_W'(w_batch);
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_grid.valid        = r_out_vld;
    assign o_grid.tiles_across = r_out_across;
    assign o_grid.tiles_down   = r_out_down;
    assign o_grid.image_total  = r_out_batch;

    assign w_run_prod = (2*CW)'(r_a) * (2*CW)'(r_b);

    `TGAS_ASSERT_NEXT(a_accept_setup, i_img.valid && i_img.ready, r_state == ST_SETUP, "accepted request did not enter setup")
    `TGAS_ASSERT_NOW(a_run_product, r_state == ST_RUN, w_run_prod == (2*CW)'(r_p), "enumerator tile count out of step")
    `TGAS_ASSERT_NOW(a_best_in_range, (r_state == ST_FINISH) && w_best_vld, (w_count <= (2*CW)'(r_top)) && ((2*CW+CNT_W)'(w_count) >= (2*CW+CNT_W)'(r_min_tiles)), "chosen grid outside tile count range")

endmodule
